// ===== rtl/core/tdp_pkg.sv =====
// Package for the trial division prime test unit.
// Holds widths, control word types, status struct and the microcode ROM.
// Used by tdp_sequencer, tdp_datapath and trial_division_prime_test_unit.
package tdp_pkg;

	localparam int VALUE_W = 32;
	localparam int DIV_W   = VALUE_W / 2;
	localparam int SQ_W    = VALUE_W + 1;
	localparam int CNT_W   = $clog2(VALUE_W);
	localparam int STEP_W  = 4;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_IN_ACC,
		C_MAG_LT2,
		C_SQ_GT,
		C_DIV_LAST,
		C_REM_ZERO,
		C_OUT_FREE
	} cond_t;

	typedef enum logic [2:0] {
		A_NONE,
		A_LOAD,
		A_DIV_INIT,
		A_DIV_STEP,
		A_ADV,
		A_SET1,
		A_SET0,
		A_EMIT
	} act_t;

	typedef struct packed {
		cond_t cond;
		step_t target;
		logic  hold;
		act_t  act;
	} ucode_t;

	typedef struct packed {
		act_t act;
	} ctrl_t;

	typedef struct packed {
		logic in_acc;
		logic mag_lt2;
		logic sq_gt;
		logic div_last;
		logic rem_zero;
		logic out_free;
	} stat_t;

	localparam step_t S_WAIT     = 4'd0;
	localparam step_t S_SMALL    = 4'd1;
	localparam step_t S_BOUND    = 4'd2;
	localparam step_t S_DIV_INIT = 4'd3;
	localparam step_t S_DIV_STEP = 4'd4;
	localparam step_t S_TEST     = 4'd5;
	localparam step_t S_ADV      = 4'd6;
	localparam step_t S_PRIME    = 4'd7;
	localparam step_t S_COMPOS   = 4'd8;
	localparam step_t S_EMIT     = 4'd9;

	// jump to target when cond holds, else stay (hold) or fall through
	function automatic ucode_t ucode(input step_t step);
		ucode_t w;
		case (step)
			S_WAIT:     w = '{C_IN_ACC,   S_SMALL,    1'b1, A_LOAD};
			S_SMALL:    w = '{C_MAG_LT2,  S_COMPOS,   1'b0, A_NONE};
			S_BOUND:    w = '{C_SQ_GT,    S_PRIME,    1'b0, A_NONE};
			S_DIV_INIT: w = '{C_NEVER,    S_WAIT,     1'b0, A_DIV_INIT};
			S_DIV_STEP: w = '{C_DIV_LAST, S_TEST,     1'b1, A_DIV_STEP};
			S_TEST:     w = '{C_REM_ZERO, S_COMPOS,   1'b0, A_NONE};
			S_ADV:      w = '{C_ALWAYS,   S_BOUND,    1'b0, A_ADV};
			S_PRIME:    w = '{C_ALWAYS,   S_EMIT,     1'b0, A_SET1};
			S_COMPOS:   w = '{C_ALWAYS,   S_EMIT,     1'b0, A_SET0};
			S_EMIT:     w = '{C_OUT_FREE, S_WAIT,     1'b1, A_EMIT};
			default:    w = '{C_ALWAYS,   S_WAIT,     1'b0, A_NONE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/tdp_sequencer.sv =====
// Microcode sequencer: step counter, control ROM lookup, conditional jumps.
// Depends on tdp_pkg.
module tdp_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  tdp_pkg::stat_t stat,
	output tdp_pkg::ctrl_t ctrl
);

	tdp_pkg::step_t  step_q;
	tdp_pkg::step_t  step_d;
	tdp_pkg::ucode_t cw;
	logic            hit;

	always_comb begin
		cw = tdp_pkg::ucode(step_q);
		case (cw.cond)
			tdp_pkg::C_NEVER:    hit = 1'b0;
			tdp_pkg::C_ALWAYS:   hit = 1'b1;
			tdp_pkg::C_IN_ACC:   hit = stat.in_acc;
			tdp_pkg::C_MAG_LT2:  hit = stat.mag_lt2;
			tdp_pkg::C_SQ_GT:    hit = stat.sq_gt;
			tdp_pkg::C_DIV_LAST: hit = stat.div_last;
			tdp_pkg::C_REM_ZERO: hit = stat.rem_zero;
			tdp_pkg::C_OUT_FREE: hit = stat.out_free;
			default:             hit = 1'b1;
		endcase
		if (hit) begin
			step_d = cw.target;
		end else if (cw.hold) begin
			step_d = step_q;
		end else begin
			step_d = step_q + 1'b1;
		end
		ctrl.act = cw.act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= tdp_pkg::S_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= tdp_pkg::S_EMIT)
		else $error("step counter out of program");
	a_accept_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.in_acc |=> step_q == tdp_pkg::S_SMALL)
		else $error("accepted word did not start a test");
	a_div_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == tdp_pkg::S_DIV_STEP && !stat.div_last) |=> step_q == tdp_pkg::S_DIV_STEP)
		else $error("divide loop left early");

endmodule

// ===== rtl/core/tdp_datapath.sv =====
// Datapath: magnitude, trial divisor, running square, bit-serial remainder
// and the output register. Depends on tdp_pkg; driven by tdp_sequencer.
module tdp_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tdp_pkg::ctrl_t              ctrl,
	output tdp_pkg::stat_t              stat,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tdp_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        is_prime
);

	localparam int VW = tdp_pkg::VALUE_W;
	localparam int DW = tdp_pkg::DIV_W;
	localparam int SW = tdp_pkg::SQ_W;
	localparam int CW = tdp_pkg::CNT_W;

	logic [VW-1:0] mag_q;
	logic [DW-1:0] div_q;
	logic [SW-1:0] sq_q;
	logic [DW-1:0] rem_q;
	logic [VW-1:0] sh_q;
	logic [CW-1:0] cnt_q;
	logic          res_q;
	logic          out_valid_q;
	logic          is_prime_q;

	logic [VW-1:0] mag_in;
	logic [DW:0]   r2;
	logic [DW+1:0] diff;
	logic [DW-1:0] rem_d;
	logic          in_acc;
	logic          out_free;

	always_comb begin
		mag_in   = value[VW-1] ? (~value + 1'b1) : value;
		r2       = {rem_q, sh_q[VW-1]};
		diff     = {1'b0, r2} - {2'b00, div_q};
		rem_d    = diff[DW+1] ? r2[DW-1:0] : diff[DW-1:0];
		in_ready = (ctrl.act == tdp_pkg::A_LOAD);
		in_acc   = in_valid && in_ready;
		out_free = !out_valid_q || out_ready;
		stat.in_acc   = in_acc;
		stat.mag_lt2  = (mag_q[VW-1:1] == '0);
		stat.sq_gt    = (sq_q > {1'b0, mag_q});
		stat.div_last = (cnt_q == CW'(VW - 1));
		stat.rem_zero = (rem_q == '0);
		stat.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q       <= '0;
			div_q       <= DW'(2);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && ctrl.act != tdp_pkg::A_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl.act)
				tdp_pkg::A_LOAD: begin
					if (in_acc) begin
						mag_q <= mag_in;
						div_q <= DW'(2);
					end
				end
				tdp_pkg::A_DIV_INIT: begin
					cnt_q <= '0;
				end
				tdp_pkg::A_DIV_STEP: begin
					cnt_q <= cnt_q + 1'b1;
				end
				tdp_pkg::A_ADV: begin
					div_q <= div_q + 1'b1;
				end
				tdp_pkg::A_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (ctrl.act)
			tdp_pkg::A_LOAD: begin
				if (in_acc) begin
					sq_q <= SW'(4);
				end
			end
			tdp_pkg::A_DIV_INIT: begin
				rem_q <= '0;
				sh_q  <= mag_q;
			end
			tdp_pkg::A_DIV_STEP: begin
				rem_q <= rem_d;
				sh_q  <= {sh_q[VW-2:0], 1'b0};
			end
			tdp_pkg::A_ADV: begin
				// (d+1)^2 = d^2 + 2d + 1
				sq_q <= sq_q + SW'({div_q, 1'b1});
			end
			tdp_pkg::A_SET1: begin
				res_q <= 1'b1;
			end
			tdp_pkg::A_SET0: begin
				res_q <= 1'b0;
			end
			tdp_pkg::A_EMIT: begin
				if (out_free) begin
					is_prime_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	a_div_floor: assert property (@(posedge clk) disable iff (!arst_n)
		div_q >= DW'(2))
		else $error("trial divisor below two");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.act == tdp_pkg::A_DIV_STEP) |-> rem_q < div_q)
		else $error("partial remainder not below divisor");
	a_small_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.act == tdp_pkg::A_SET1) |-> !stat.mag_lt2)
		else $error("magnitude below two marked prime");

endmodule

// ===== rtl/core/trial_division_prime_test_unit.sv =====
// Trial division prime test unit: takes one signed word and returns one flag,
// set when the magnitude of the word is prime (0 and 1 give 0, and so does the
// most negative value). Divisors 2, 3, 4, ... are tried until one divides or
// its square exceeds the magnitude. Each trial divisor passes the bound check,
// the divider setup, the bit-serial remainder unit (one quotient bit per step),
// and the test and advance steps of the microcode. One word is in work at a
// time; the next word is taken while the previous flag still waits in the
// output register.
// Depends on tdp_pkg, tdp_sequencer and tdp_datapath.
module trial_division_prime_test_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [tdp_pkg::VALUE_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               is_prime
);

	tdp_pkg::ctrl_t ctrl;
	tdp_pkg::stat_t stat;

	tdp_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	tdp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_prime  (is_prime)
	);

endmodule

// ===== bench/trial_division_prime_test_unit_tb.sv =====
// Testbench for trial_division_prime_test_unit: directed table, then random words under
// varying handshake idling, each flag checked in order against its typed value or a local
// trial-division model. Depends on tdp_pkg and the trial_division_prime_test_unit RTL.
module trial_division_prime_test_unit_tb;

	typedef struct packed {
		logic [tdp_pkg::VALUE_W-1:0] v;
		logic                        typed;
		logic                        flag;
	} row_t;

	localparam int DIR_N = 22;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic signed [tdp_pkg::VALUE_W-1:0] value = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               is_prime;

	bit pending_flags[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int rx_hold_left = 0;

	// typed flags only where obvious; the rest come from prime_flag_of
	row_t dir_rows [DIR_N] = '{
		'{32'd0,          1'b1, 1'b0},
		'{32'd1,          1'b1, 1'b0},
		'{-32'sd1,        1'b1, 1'b0},
		'{32'd2,          1'b1, 1'b1},
		'{-32'sd2,        1'b1, 1'b1},
		'{32'd3,          1'b1, 1'b1},
		'{32'd4,          1'b1, 1'b0},
		'{32'h8000_0000,  1'b1, 1'b0},
		'{32'h7FFF_FFFE,  1'b1, 1'b0},
		'{-32'sd2147483646, 1'b1, 1'b0},
		'{32'd7,          1'b0, 1'b0},
		'{32'd9,          1'b0, 1'b0},
		'{32'd25,         1'b0, 1'b0},
		'{-32'sd49,       1'b0, 1'b0},
		'{32'd121,        1'b0, 1'b0},
		'{-32'sd97,       1'b0, 1'b0},
		'{32'd32749,      1'b0, 1'b0},
		'{32'd65521,      1'b0, 1'b0},
		'{32'd1000003,    1'b0, 1'b0},
		'{32'd2147395600, 1'b0, 1'b0},
		'{32'd2147483643, 1'b0, 1'b0},
		'{32'hC000_0000,  1'b0, 1'b0}
	};

	trial_division_prime_test_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.is_prime  (is_prime)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// magnitude of the two's complement word, then divisors 2, 3, ... up to its root
	function automatic bit prime_flag_of(input logic [tdp_pkg::VALUE_W-1:0] v);
		logic [tdp_pkg::VALUE_W:0] mag;
		logic [tdp_pkg::VALUE_W:0] d;
		mag = v[tdp_pkg::VALUE_W-1] ? {1'b0, -v} : {1'b0, v};
		if (mag < 2)
			return 1'b0;
		for (d = 2; d <= mag / d; d++) begin
			if (mag % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// mostly small magnitudes; wide words only with a small factor
	function automatic logic [tdp_pkg::VALUE_W-1:0] random_word();
		logic [tdp_pkg::VALUE_W-1:0] mag;
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			mag = $urandom_range(4095);
		else if (pick < 60)
			mag = $urandom_range(262143);
		else if (pick < 85)
			return $urandom() & ~32'd1;
		else
			mag = $urandom_range(715827882) * 3;
		return $urandom_range(1) ? -mag : mag;
	endfunction

	// entered and left at a falling edge
	task automatic send_word(input logic [tdp_pkg::VALUE_W-1:0] v, input bit typed,
		input bit flag);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_flags.push_back(typed ? flag : prime_flag_of(v));
		@(negedge clk);
	endtask

	task automatic drain_flags();
		in_valid <= 1'b0;
		while (pending_flags.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		bit want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_flags.size() == 0) begin
				$display("%0t: unexpected word, expected none, got is_prime=%0b",
					$time, is_prime);
				errors++;
			end else begin
				want = pending_flags.pop_front();
				if (is_prime !== want) begin
					$display("%0t: is_prime mismatch, expected %0b, got %0b",
						$time, want, is_prime);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 17;
		recv_idle_pct = 85;
		for (int i = 0; i < DIR_N; i++)
			send_word(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].flag);
		for (int i = 0; i < 26; i++)
			send_word(random_word(), 1'b0, 1'b0);
		drain_flags();

		send_idle_pct = 85;
		recv_idle_pct = 17;
		for (int i = 0; i < 26; i++)
			send_word(random_word(), 1'b0, 1'b0);
		drain_flags();

		// long receiver stall with back-to-back words to fill the unit
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rx_hold_left = 2000;
		for (int i = 0; i < 8; i++)
			send_word($urandom_range(200), 1'b0, 1'b0);
		for (int i = 0; i < 18; i++)
			send_word(random_word(), 1'b0, 1'b0);
		drain_flags();

		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== trial_division_prime_test_unit.f =====
rtl/core/tdp_pkg.sv
rtl/core/tdp_sequencer.sv
rtl/core/tdp_datapath.sv
rtl/core/trial_division_prime_test_unit.sv
bench/trial_division_prime_test_unit_tb.sv
